// File: design/d2q9pe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// D2Q9 pressure equilibrium package
// Lattice directions, weights, register codes and pipeline constants.
// ----------------------------------------------------------------------------
package d2q9pe_pkg;

  localparam int NUM_DIRS = 9;
  localparam int CFG_IDX_W = 3;
  localparam int MUL_LAT = 4;
  localparam int LANE_LAT = 25;

  localparam int DIR_X [NUM_DIRS] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int DIR_Y [NUM_DIRS] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
  localparam int WGT_NUM [NUM_DIRS] = '{4, 1, 1, 1, 1, 1, 1, 1, 1};
  localparam int WGT_DEN [NUM_DIRS] = '{9, 9, 9, 9, 9, 36, 36, 36, 36};

  localparam logic [CFG_IDX_W-1:0] REG_CS2 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CS4 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CS2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CS4 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CS6 = 3'd4;

  localparam logic [63:0] RST_CS2 = 64'd1431655765;
  localparam logic [63:0] RST_CS4 = 64'd477218588;
  localparam logic [63:0] RST_INV_CS2 = 64'd12884901888;
  localparam logic [63:0] RST_INV_CS4 = 64'd38654705664;
  localparam logic [63:0] RST_INV_CS6 = 64'd115964116992;

endpackage
`default_nettype wire

// File: design/d2q9_pressure_equilibrium_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// D2Q9 pressure equilibrium
// Nine lattice Boltzmann equilibrium populations per node from density,
// velocity and pressure, in saturating signed fixed point.
// ----------------------------------------------------------------------------
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    density, velocity x/y, pressure
//   out      output     out_valid/out_ready  nine populations
//   cfg      input      cfg_valid/cfg_ready  register index and data
//
// One item enters per cycle while no result waits stalled at the output;
// each direction lane is built from chained four-stage multipliers.
// Reset restores the sound speed registers and empties the pipeline.
// A result waiting at the output freezes the whole pipeline in place.
// ----------------------------------------------------------------------------
module d2q9_pressure_equilibrium_top import d2q9pe_pkg::*; #(
  parameter int VALUE_WIDTH = 48,
  parameter int FRAC_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [VALUE_WIDTH-1:0] in_density,
  input  wire logic signed [VALUE_WIDTH-1:0] in_vel_x,
  input  wire logic signed [VALUE_WIDTH-1:0] in_vel_y,
  input  wire logic signed [VALUE_WIDTH-1:0] in_node_pressure,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0]      out_pop_rest,
  output logic signed [VALUE_WIDTH-1:0]      out_pop_east,
  output logic signed [VALUE_WIDTH-1:0]      out_pop_north,
  output logic signed [VALUE_WIDTH-1:0]      out_pop_west,
  output logic signed [VALUE_WIDTH-1:0]      out_pop_south,
  output logic signed [VALUE_WIDTH-1:0]      out_pop_north_east,
  output logic signed [VALUE_WIDTH-1:0]      out_pop_north_west,
  output logic signed [VALUE_WIDTH-1:0]      out_pop_south_west,
  output logic signed [VALUE_WIDTH-1:0]      out_pop_south_east,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [VALUE_WIDTH-2:0]        cfg_data
);

  localparam int W = VALUE_WIDTH;
  localparam int F = FRAC_BITS;

  logic [W-2:0] cs2_r, cs4_r, inv2_r, inv4_r, inv6_r;
  logic signed [W-1:0] cs2, cs4, inv2, inv4, inv6;
  logic signed [W-1:0] rho_r, ux_r, uy_r, prs_r;
  logic [LANE_LAT-1:0] vld_r;
  logic en;
  logic signed [W-1:0] pop_w [NUM_DIRS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs2_r <= (W-1)'(RST_CS2);
      cs4_r <= (W-1)'(RST_CS4);
      inv2_r <= (W-1)'(RST_INV_CS2);
      inv4_r <= (W-1)'(RST_INV_CS4);
      inv6_r <= (W-1)'(RST_INV_CS6);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CS2: cs2_r <= cfg_data;
        REG_CS4: cs4_r <= cfg_data;
        REG_INV_CS2: inv2_r <= cfg_data;
        REG_INV_CS4: inv4_r <= cfg_data;
        REG_INV_CS6: inv6_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cs2 = {1'b0, cs2_r};
  assign cs4 = {1'b0, cs4_r};
  assign inv2 = {1'b0, inv2_r};
  assign inv4 = {1'b0, inv4_r};
  assign inv6 = {1'b0, inv6_r};

  assign en = !vld_r[LANE_LAT-1] || out_ready;
  assign in_ready = en;
  assign out_valid = vld_r[LANE_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LANE_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rho_r <= in_density;
      ux_r <= in_vel_x;
      uy_r <= in_vel_y;
      prs_r <= in_node_pressure;
    end
  end

  for (genvar k = 0; k < NUM_DIRS; k++) begin : g_lane
    d2q9pe_lane #(.W(W), .F(F), .K(k)) u_lane (
      .clk, .en,
      .cs2, .cs4, .inv2, .inv4, .inv6,
      .rho(rho_r), .ux(ux_r), .uy(uy_r), .prs(prs_r),
      .pop(pop_w[k])
    );
  end

  assign out_pop_rest = pop_w[0];
  assign out_pop_east = pop_w[1];
  assign out_pop_north = pop_w[2];
  assign out_pop_west = pop_w[3];
  assign out_pop_south = pop_w[4];
  assign out_pop_north_east = pop_w[5];
  assign out_pop_north_west = pop_w[6];
  assign out_pop_south_west = pop_w[7];
  assign out_pop_south_east = pop_w[8];

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted item did not enter the pipeline");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(vld_r))
    else $error("pipeline moved while the output was stalled");

  a_last_stage_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[LANE_LAT-2] && in_ready) |=> out_valid)
    else $error("item lost before the output stage");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire

// File: design/d2q9pe_dly.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Delay line
// Holds a value for a fixed number of pipeline stages, frozen on stall.
// ----------------------------------------------------------------------------
module d2q9pe_dly #(
  parameter int W = 48,
  parameter int N = 1
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic signed [W-1:0] d,
  output logic signed [W-1:0]      q
);

  logic signed [W-1:0] sr_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q = sr_r[N-1];

endmodule
`default_nettype wire

// File: design/d2q9pe_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed point multiplier
// Four stage signed multiply from half-width partial products, rounded to
// nearest with ties away from zero, then saturated.
// ----------------------------------------------------------------------------
module d2q9pe_mul #(
  parameter int W = 48,
  parameter int F = 32
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic signed [W-1:0] a,
  input  wire logic signed [W-1:0] b,
  output logic signed [W-1:0]      p
);

  localparam int H = (W + 1) / 2;
  localparam int PW = 2 * H;
  localparam int SW = 4 * H;
  localparam logic [W-1:0] VMAXU = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMINU = {1'b1, {(W-1){1'b0}}};
  localparam logic [SW-1:0] RND = SW'(1) << (F - 1);

  logic [W-1:0]  ua, ub, ma_nxt, mb_nxt, ma_r, mb_r;
  logic          neg1_r, neg2_r, neg3_r;
  logic [PW-1:0] ea, eb;
  logic [H-1:0]  a0, a1, b0, b1;
  logic [PW-1:0] p00_r, p01_r, p10_r, p11_r;
  logic [SW-1:0] sum_nxt, sum_r, q, lim;
  logic [W-1:0]  r, res_nxt;

  always_comb begin
    ua = a;
    ub = b;
    ma_nxt = ua[W-1] ? (~ua + 1'b1) : ua;
    mb_nxt = ub[W-1] ? (~ub + 1'b1) : ub;
    ea = PW'(ma_r);
    eb = PW'(mb_r);
    a0 = ea[H-1:0];
    a1 = ea[PW-1:H];
    b0 = eb[H-1:0];
    b1 = eb[PW-1:H];
    sum_nxt = SW'(p00_r) + (SW'(p01_r) << H) + (SW'(p10_r) << H)
            + (SW'(p11_r) << PW) + RND;
    q = sum_r >> F;
    lim = SW'(VMAXU) + SW'(neg3_r);
    r = q[W-1:0];
    if (q > lim) begin
      res_nxt = neg3_r ? VMINU : VMAXU;
    end else begin
      res_nxt = neg3_r ? (~r + 1'b1) : r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r <= ma_nxt;
      mb_r <= mb_nxt;
      neg1_r <= a[W-1] ^ b[W-1];
      p00_r <= {{H{1'b0}}, a0} * {{H{1'b0}}, b0};
      p01_r <= {{H{1'b0}}, a0} * {{H{1'b0}}, b1};
      p10_r <= {{H{1'b0}}, a1} * {{H{1'b0}}, b0};
      p11_r <= {{H{1'b0}}, a1} * {{H{1'b0}}, b1};
      neg2_r <= neg1_r;
      sum_r <= sum_nxt;
      neg3_r <= neg2_r;
      p <= res_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/d2q9pe_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Population lane
// Pipelined equilibrium population for one lattice direction, with the
// coefficients that depend only on the sound speed registers kept in
// free-running registers beside the item path.
// ----------------------------------------------------------------------------
module d2q9pe_lane import d2q9pe_pkg::*; #(
  parameter int W = 48,
  parameter int F = 32,
  parameter int K = 0
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic signed [W-1:0] cs2,
  input  wire logic signed [W-1:0] cs4,
  input  wire logic signed [W-1:0] inv2,
  input  wire logic signed [W-1:0] inv4,
  input  wire logic signed [W-1:0] inv6,
  input  wire logic signed [W-1:0] rho,
  input  wire logic signed [W-1:0] ux,
  input  wire logic signed [W-1:0] uy,
  input  wire logic signed [W-1:0] prs,
  output logic signed [W-1:0]      pop
);

  localparam int EX = DIR_X[K];
  localparam int EY = DIR_Y[K];
  localparam int EXY = EX * EY;
  localparam bit SX = (EX != 0);
  localparam bit SY = (EY != 0);
  localparam logic [63:0] WGT64 =
    ((64'(WGT_NUM[K]) << F) * 64'd2 + 64'(WGT_DEN[K])) / (64'd2 * 64'(WGT_DEN[K]));
  localparam logic signed [W-1:0] WGT = W'(WGT64);
  localparam logic signed [W-1:0] ONE = W'(64'd1 << F);
  localparam logic signed [W-1:0] ZERO = '0;
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  function automatic logic signed [W-1:0] fx_add(input logic signed [W-1:0] x,
                                                 input logic signed [W-1:0] y);
    logic signed [W:0] s;
    s = {x[W-1], x} + {y[W-1], y};
    if (s[W] != s[W-1]) begin
      return s[W] ? VMIN : VMAX;
    end
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] fx_neg(input logic signed [W-1:0] x);
    return (x == VMIN) ? VMAX : -x;
  endfunction

  function automatic logic signed [W-1:0] fx_sub(input logic signed [W-1:0] x,
                                                 input logic signed [W-1:0] y);
    return fx_add(x, fx_neg(y));
  endfunction

  function automatic logic signed [W-1:0] fx_sel(input logic signed [W-1:0] x,
                                                 input int e);
    if (e > 0) begin
      return x;
    end else if (e < 0) begin
      return fx_neg(x);
    end
    return ZERO;
  endfunction

  function automatic logic signed [W-1:0] fx_half(input logic signed [W-1:0] x);
    logic signed [W:0] t;
    t = {x[W-1], x} + {{W{1'b0}}, ~x[W-1]};
    return t[W:1];
  endfunction

  function automatic logic signed [W-1:0] fx_quarter(input logic signed [W-1:0] x);
    logic signed [W:0] t;
    t = {x[W-1], x} + (x[W-1] ? (W+1)'(1) : (W+1)'(2));
    return {t[W], t[W:2]};
  endfunction

  // Coefficients that follow the registers.
  logic signed [W-1:0] hxx_r, hyy_r, c2x2_r, c2n_r;
  logic signed [W-1:0] hsum_r, hxxy_r, hyyx_r, three_r, hxxyya_r;
  logic signed [W-1:0] omt_r, hxxyy_r, hxxx_r, hyyy_r, coefx_r, coefy_r;
  logic signed [W-1:0] ea_w, eb_w, esub_r, e_w;

  always_ff @(posedge clk) begin
    hxx_r <= fx_sub(SX ? ONE : ZERO, cs2);
    hyy_r <= fx_sub(SY ? ONE : ZERO, cs2);
    c2x2_r <= fx_add(cs2, cs2);
    c2n_r <= fx_add(SX ? cs2 : ZERO, SY ? cs2 : ZERO);
    hsum_r <= fx_add(hxx_r, hyy_r);
    hxxy_r <= fx_sel(hxx_r, EY);
    hyyx_r <= fx_sel(hyy_r, EX);
    three_r <= fx_add(c2x2_r, cs2);
    hxxyya_r <= fx_sub((SX && SY) ? ONE : ZERO, c2n_r);
    omt_r <= fx_sub(ONE, three_r);
    hxxyy_r <= fx_add(hxxyya_r, cs4);
    hxxx_r <= fx_sel(omt_r, EX);
    hyyy_r <= fx_sel(omt_r, EY);
    coefx_r <= fx_add(hyyx_r, hxxx_r);
    coefy_r <= fx_add(hyyy_r, hxxy_r);
    esub_r <= fx_sub(fx_half(ea_w), fx_quarter(eb_w));
  end

  d2q9pe_mul #(.W(W), .F(F)) u_ea (.clk, .en(1'b1), .a(hsum_r), .b(inv4), .p(ea_w));
  d2q9pe_mul #(.W(W), .F(F)) u_eb (.clk, .en(1'b1), .a(hxxyy_r), .b(inv6), .p(eb_w));
  d2q9pe_mul #(.W(W), .F(F)) u_e (.clk, .en(1'b1), .a(WGT), .b(esub_r), .p(e_w));

  // Item path.
  logic signed [W-1:0] uxux4, uyuy4, uxuy4, rhow4, rc2_4;
  logic signed [W-1:0] selux1_r, seluy1_r, lx5, ly5, p4, dev5_r, ux5, uy5;
  logic signed [W-1:0] cx9, cy9, qa8, qb8, qb9, uxs5_r, uxs6_r, uxs8;
  logic signed [W-1:0] q9_r, q10_r, q14, lin6_r, ol7_r, ol14, s15_r, rhow15, t1_19;
  logic signed [W-1:0] cub10_r, wc14, wci18, corr19_r, dev19, dc23, t1_23;

  d2q9pe_mul #(.W(W), .F(F)) u_uxux (.clk, .en, .a(ux), .b(ux), .p(uxux4));
  d2q9pe_mul #(.W(W), .F(F)) u_uyuy (.clk, .en, .a(uy), .b(uy), .p(uyuy4));
  d2q9pe_mul #(.W(W), .F(F)) u_uxuy (.clk, .en, .a(ux), .b(uy), .p(uxuy4));
  d2q9pe_mul #(.W(W), .F(F)) u_rhow (.clk, .en, .a(rho), .b(WGT), .p(rhow4));
  d2q9pe_mul #(.W(W), .F(F)) u_rc2 (.clk, .en, .a(rho), .b(cs2), .p(rc2_4));
  d2q9pe_mul #(.W(W), .F(F)) u_lx (.clk, .en, .a(selux1_r), .b(inv2), .p(lx5));
  d2q9pe_mul #(.W(W), .F(F)) u_ly (.clk, .en, .a(seluy1_r), .b(inv2), .p(ly5));
  d2q9pe_mul #(.W(W), .F(F)) u_cx (.clk, .en, .a(ux5), .b(coefx_r), .p(cx9));
  d2q9pe_mul #(.W(W), .F(F)) u_cy (.clk, .en, .a(uy5), .b(coefy_r), .p(cy9));
  d2q9pe_mul #(.W(W), .F(F)) u_qa (.clk, .en, .a(uxux4), .b(hxx_r), .p(qa8));
  d2q9pe_mul #(.W(W), .F(F)) u_qb (.clk, .en, .a(uyuy4), .b(hyy_r), .p(qb8));
  d2q9pe_mul #(.W(W), .F(F)) u_q (.clk, .en, .a(q10_r), .b(inv4), .p(q14));
  d2q9pe_mul #(.W(W), .F(F)) u_t1 (.clk, .en, .a(rhow15), .b(s15_r), .p(t1_19));
  d2q9pe_mul #(.W(W), .F(F)) u_wc (.clk, .en, .a(WGT), .b(cub10_r), .p(wc14));
  d2q9pe_mul #(.W(W), .F(F)) u_wci (.clk, .en, .a(wc14), .b(inv6), .p(wci18));
  d2q9pe_mul #(.W(W), .F(F)) u_dc (.clk, .en, .a(dev19), .b(corr19_r), .p(dc23));

  d2q9pe_dly #(.W(W), .N(4)) u_dly_p (.clk, .en, .d(prs), .q(p4));
  d2q9pe_dly #(.W(W), .N(5)) u_dly_ux (.clk, .en, .d(ux), .q(ux5));
  d2q9pe_dly #(.W(W), .N(5)) u_dly_uy (.clk, .en, .d(uy), .q(uy5));
  d2q9pe_dly #(.W(W), .N(2)) u_dly_uxs (.clk, .en, .d(uxs6_r), .q(uxs8));
  d2q9pe_dly #(.W(W), .N(1)) u_dly_qb (.clk, .en, .d(qb8), .q(qb9));
  d2q9pe_dly #(.W(W), .N(7)) u_dly_ol (.clk, .en, .d(ol7_r), .q(ol14));
  d2q9pe_dly #(.W(W), .N(11)) u_dly_rhow (.clk, .en, .d(rhow4), .q(rhow15));
  d2q9pe_dly #(.W(W), .N(14)) u_dly_dev (.clk, .en, .d(dev5_r), .q(dev19));
  d2q9pe_dly #(.W(W), .N(4)) u_dly_t1 (.clk, .en, .d(t1_19), .q(t1_23));

  always_ff @(posedge clk) begin
    if (en) begin
      selux1_r <= fx_sel(ux, EX);
      seluy1_r <= fx_sel(uy, EY);
      dev5_r <= fx_sub(p4, rc2_4);
      uxs5_r <= fx_sel(uxuy4, EXY);
      uxs6_r <= fx_add(uxs5_r, uxs5_r);
      lin6_r <= fx_add(lx5, ly5);
      ol7_r <= fx_add(ONE, lin6_r);
      q9_r <= fx_add(qa8, uxs8);
      q10_r <= fx_add(q9_r, qb9);
      cub10_r <= fx_add(cx9, cy9);
      s15_r <= fx_add(ol14, fx_half(q14));
      corr19_r <= fx_add(e_w, fx_half(wci18));
      pop <= fx_add(t1_23, dc23);
    end
  end

endmodule
`default_nettype wire
